// ----- hdl/csi_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// control sequence parser. No dependencies.
package csi_pkg;

  // Sizing
  localparam int MAX_PARAMS = 16;
  localparam int PARAM_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_PARAMS);
  localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
  localparam int ACC_W      = PARAM_BITS + 4;

  // Port field widths
  localparam int BYTE_W     = 8;
  localparam int OUT_IDX_W  = 4;
  localparam int OUT_VAL_W  = 16;
  localparam int OUT_TOT_W  = 5;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTRODUCER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPENING    = 1'd1;

  // Reset values of the start pair
  localparam logic [BYTE_W-1:0] INTRODUCER_RST = 8'd27;
  localparam logic [BYTE_W-1:0] OPENING_RST    = 8'd91;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;

  localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'((64'd1 << PARAM_BITS) - 64'd1);

  // Controller to datapath
  typedef struct packed {
    logic byte_take;  // an input item is accepted this cycle
    logic rd_en;      // read the parameter store at the run index
    logic out_load;   // load the output register from read data
  } csi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic seq_end;    // the offered byte is a letter inside a sequence
    logic run_last;   // the run index points at the final kept parameter
    logic slot_free;  // the output register can take a new item
  } csi_sts_t;

endpackage

// ----- hdl/csi_ctrl.sv -----
// Controller for the control sequence parser: takes bytes while idle and
// steps the result run out of the parameter store. Uses csi_pkg.
module csi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  csi_pkg::csi_sts_t sts,
  output csi_pkg::csi_cmd_t cmd
);
  import csi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_LD   = 3'b100
  } csi_state_t;

  csi_state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.byte_take = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.out_load  = 1'b0;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.byte_take = in_valid;
        if (in_valid && sts.seq_end) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.run_last ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // A sequence-ending letter starts a read of the store next cycle
  a_end_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.byte_take && sts.seq_end |=> cmd.rd_en)
    else $error("run did not start after sequence end");

  // The load state is entered only right after a store read
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LD) && ($past(state_r) != ST_LD) |-> $past(cmd.rd_en))
    else $error("output load without a store read");

  // No byte is taken during a run
  a_no_take_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en || cmd.out_load |-> !cmd.byte_take)
    else $error("byte taken during result run");
`endif

endmodule

// ----- hdl/csi_dp.sv -----
// Datapath for the control sequence parser: start-pair registers, byte
// classification, decimal accumulator, parameter store and output register.
// Uses csi_pkg.
module csi_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [csi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csi_pkg::BYTE_W-1:0]      cfg_wdata,
  input  logic [csi_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            out_stall,
  input  csi_pkg::csi_cmd_t               cmd,
  output csi_pkg::csi_sts_t               sts,
  output logic                            out_valid,
  output logic [csi_pkg::BYTE_W-1:0]      out_final_letter,
  output logic [csi_pkg::OUT_IDX_W-1:0]   out_param_index,
  output logic [csi_pkg::OUT_VAL_W-1:0]   out_param_value,
  output logic [csi_pkg::OUT_TOT_W-1:0]   out_param_total,
  output logic                            out_too_many,
  output logic                            out_last
);
  import csi_pkg::*;

  logic [BYTE_W-1:0]     intro_r, open_r, prev_r, letter_r;
  logic                  in_seq_r;
  logic [PARAM_BITS-1:0] acc_r;
  logic [CNT_W-1:0]      count_r;
  logic                  ovf_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic [PARAM_BITS-1:0] rd_data_r;
  logic [PARAM_BITS-1:0] store_mem [MAX_PARAMS];

  logic                  is_letter, is_digit, is_semi, store_ok, do_store;
  logic [ACC_W-1:0]      acc_prod, acc_sum;
  logic [PARAM_BITS-1:0] acc_sat;

  // Classify the offered byte
  assign is_letter = ((in_byte >= CH_UP_A) && (in_byte <= CH_UP_Z)) ||
                     ((in_byte >= CH_LO_A) && (in_byte <= CH_LO_Z));
  assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign is_semi   = (in_byte == CH_SEMI);
  assign store_ok  = (count_r < CNT_W'(MAX_PARAMS));
  assign do_store  = cmd.byte_take && in_seq_r && (is_letter || is_semi);

  // Accumulate one decimal digit, saturating
  assign acc_prod = ACC_W'(acc_r) * ACC_W'(10);
  assign acc_sum  = acc_prod + ACC_W'(in_byte - CH_ZERO);
  assign acc_sat  = (acc_sum > ACC_MAX) ? ACC_MAX[PARAM_BITS-1:0]
                                        : acc_sum[PARAM_BITS-1:0];

  // Status to the controller
  assign sts.seq_end   = in_seq_r && is_letter;
  assign sts.run_last  = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r);
  assign sts.slot_free = !out_valid || !out_stall;

  // Start-pair registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intro_r <= INTRODUCER_RST;
      open_r  <= OPENING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTRODUCER: intro_r <= cfg_wdata;
        REG_OPENING:    open_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequence tracking, accumulator and parameter count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      in_seq_r <= 1'b0;
      acc_r    <= '0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.byte_take) begin
        prev_r <= in_byte;
        if (!in_seq_r) begin
          if ((prev_r == intro_r) && (in_byte == open_r)) begin
            in_seq_r <= 1'b1;
            acc_r    <= '0;
            count_r  <= '0;
            ovf_r    <= 1'b0;
          end
        end else if (is_letter) begin
          in_seq_r <= 1'b0;
          rd_idx_r <= '0;
        end else if (is_semi) begin
          acc_r <= '0;
        end else if (is_digit) begin
          acc_r <= acc_sat;
        end else begin
          in_seq_r <= 1'b0;
        end
        if (do_store) begin
          if (store_ok) begin
            count_r <= count_r + CNT_W'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end
      end
      if (cmd.out_load) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
    end
  end

  // Hold the ending letter for the run
  always_ff @(posedge clk) begin
    if (cmd.byte_take && sts.seq_end) begin
      letter_r <= in_byte;
    end
  end

  // Parameter store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_store && store_ok) begin
      store_mem[count_r[IDX_W-1:0]] <= acc_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= store_mem[rd_idx_r];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_final_letter <= letter_r;
      out_param_index  <= OUT_IDX_W'(rd_idx_r);
      out_param_value  <= OUT_VAL_W'(rd_data_r);
      out_param_total  <= OUT_TOT_W'(count_r);
      out_too_many     <= ovf_r;
      out_last         <= sts.run_last;
    end
  end

endmodule

// ----- hdl/ansi_csi_sequence_parser.sv -----
// Top level of the control sequence parser: joins the controller and the
// datapath. Uses csi_pkg, csi_ctrl and csi_dp.
//
// Takes one terminal byte per item and reports each finished control
// sequence (introducer byte, opening byte, decimal parameters separated by
// semicolons, ending letter) as a run of items, one per kept parameter, in
// order, with the ending letter, the parameter count, an overflow flag and
// a last marker. After the ending letter the block steps through each kept
// parameter (a registered read of the parameter store, then a load of the
// output register) with in_stall high; each load waits while out_stall
// holds the output register full. Up to 16 parameters are kept, values
// saturate at 65535. The start-pair bytes are written through the cfg port;
// the user must write them only while idle, as the block itself leaves this
// unchecked.
module ansi_csi_sequence_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [csi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csi_pkg::BYTE_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [csi_pkg::BYTE_W-1:0]      in_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [csi_pkg::BYTE_W-1:0]      out_final_letter,
  output logic [csi_pkg::OUT_IDX_W-1:0]   out_param_index,
  output logic [csi_pkg::OUT_VAL_W-1:0]   out_param_value,
  output logic [csi_pkg::OUT_TOT_W-1:0]   out_param_total,
  output logic                            out_too_many,
  output logic                            out_last
);
  import csi_pkg::*;

  csi_cmd_t cmd;
  csi_sts_t sts;

  csi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  csi_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_byte          (in_byte),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_final_letter (out_final_letter),
    .out_param_index  (out_param_index),
    .out_param_value  (out_param_value),
    .out_param_total  (out_param_total),
    .out_too_many     (out_too_many),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // Each result index lies inside its run
  a_index_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (OUT_TOT_W'(out_param_index) < out_param_total))
    else $error("parameter index beyond run length");

  // The last marker sits on the final index of the run
  a_last_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      ((OUT_TOT_W'(out_param_index) + OUT_TOT_W'(1)) == out_param_total))
    else $error("last marker on wrong index");

  // Input stays stalled while a run is pending in the output register
  a_stall_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken in the middle of a run");
`endif

endmodule

// ----- bench/ansi_csi_sequence_parser_test.sv -----
// Self-checking testbench for ansi_csi_sequence_parser: predicts the
// parameter items of each control sequence and checks them on the fly.
// Depends on csi_pkg and the ansi_csi_sequence_parser RTL.
`timescale 1ns / 100ps

module ansi_csi_sequence_parser_test;

  import csi_pkg::*;

  localparam logic [BYTE_W-1:0] CH_QUESTION    = 8'h3F;
  localparam int unsigned       PARAM_CEILING  = (1 << PARAM_BITS) - 1;
  localparam int                ITEMS_PER_PHASE = 92;
  localparam int                SETTLE_CYCLES  = 40;
  localparam int                WATCHDOG_LIMIT = 1000;

  // One parameter item as it leaves the block
  typedef struct packed {
    logic [BYTE_W-1:0]    letter;
    logic [OUT_IDX_W-1:0] index;
    logic [OUT_VAL_W-1:0] value;
    logic [OUT_TOT_W-1:0] total;
    logic                 too_many;
    logic                 last;
  } csi_param_t;

  // Mirror of the parser state; turns accepted bytes into expected items
  class csi_scoreboard;
    logic [BYTE_W-1:0] introducer = INTRODUCER_RST;
    logic [BYTE_W-1:0] opening    = OPENING_RST;
    logic [BYTE_W-1:0] prev_char  = '0;
    bit                in_seq     = 1'b0;
    int unsigned       acc        = 0;
    int                kept       = 0;
    bit                dropped    = 1'b0;
    int unsigned       kept_vals [MAX_PARAMS];
    csi_param_t        param_q [$];
    int                errors     = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      case (idx)
        REG_INTRODUCER: introducer = val;
        REG_OPENING:    opening = val;
        default: ;
      endcase
    endfunction

    function void keep_param();
      if (kept < MAX_PARAMS) begin
        kept_vals[kept] = acc;
        kept++;
      end else begin
        dropped = 1'b1;
      end
    endfunction

    function void take_byte(logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] p;
      csi_param_t        item;
      p = prev_char;
      prev_char = c;
      if (!in_seq) begin
        // look for the start pair only while outside a sequence
        if (p == introducer && c == opening) begin
          in_seq  = 1'b1;
          kept    = 0;
          acc     = 0;
          dropped = 1'b0;
        end
      end else if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)) begin
        // end the sequence and queue one item per kept parameter
        keep_param();
        in_seq = 1'b0;
        for (int k = 0; k < kept; k++) begin
          item.letter   = c;
          item.index    = OUT_IDX_W'(k);
          item.value    = OUT_VAL_W'(kept_vals[k]);
          item.total    = OUT_TOT_W'(kept);
          item.too_many = dropped;
          item.last     = (k + 1 == kept);
          param_q.push_back(item);
        end
      end else if (c == CH_SEMI) begin
        keep_param();
        acc = 0;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        // accumulate the digit, saturate at the top of the range
        acc = acc * 10 + int'(c - CH_ZERO);
        if (acc > PARAM_CEILING) acc = PARAM_CEILING;
      end else begin
        in_seq = 1'b0;
      end
    endfunction

    function bit field_ok(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void match_param(csi_param_t got);
      csi_param_t exp;
      bit         ok;
      if (param_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got letter %0d index %0d value %0d",
                 $time, got.letter, got.index, got.value);
        errors++;
      end else begin
        exp = param_q.pop_front();
        ok = field_ok("final_letter", exp.letter, got.letter);
        ok = field_ok("param_index", exp.index, got.index) && ok;
        ok = field_ok("param_value", exp.value, got.value) && ok;
        ok = field_ok("param_total", exp.total, got.total) && ok;
        ok = field_ok("too_many", exp.too_many, got.too_many) && ok;
        ok = field_ok("last", exp.last, got.last) && ok;
        if (!ok) errors++;
      end
    endfunction

    function int pending();
      return param_q.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_INTRODUCER;
  logic [BYTE_W-1:0]    cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_byte   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_final_letter;
  logic [OUT_IDX_W-1:0] out_param_index;
  logic [OUT_VAL_W-1:0] out_param_value;
  logic [OUT_TOT_W-1:0] out_param_total;
  logic                 out_too_many;
  logic                 out_last;

  csi_scoreboard        sb = new();
  logic [BYTE_W-1:0]    stim_q [$];
  int                   src_idle_pct = 0;
  int                   dst_stall_pct = 0;

  ansi_csi_sequence_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_final_letter (out_final_letter),
    .out_param_index  (out_param_index),
    .out_param_value  (out_param_value),
    .out_param_total  (out_param_total),
    .out_too_many     (out_too_many),
    .out_last         (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one byte, hold it until taken, then note it in the predictor
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    logic taken;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    taken    = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = (in_stall == 1'b0);
      if (taken) sb.take_byte(b);
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Send the queued bytes, then drain every expected item and let the block settle
  task automatic run_phase();
    while (stim_q.size() != 0) send_byte(stim_q.pop_front());
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Queue one control sequence with random content, sometimes broken, plus noise
  function automatic void add_sequence();
    int tokens;
    int digits;
    int r;
    r = $urandom_range(99);
    if (r < 70) tokens = $urandom_range(4, 1);
    else if (r < 85) tokens = $urandom_range(15, 5);
    else tokens = $urandom_range(20, 16);
    stim_q.push_back(sb.introducer);
    stim_q.push_back(sb.opening);
    for (int t = 0; t < tokens; t++) begin
      if (t > 0) stim_q.push_back(CH_SEMI);
      digits = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(3, 0);
      for (int d = 0; d < digits; d++) stim_q.push_back(BYTE_W'(CH_ZERO + $urandom_range(9)));
    end
    r = $urandom_range(99);
    if (r < 85) begin
      if ($urandom_range(1) == 1) stim_q.push_back(BYTE_W'(CH_UP_A + $urandom_range(25)));
      else stim_q.push_back(BYTE_W'(CH_LO_A + $urandom_range(25)));
    end else if (r < 92) begin
      stim_q.push_back(CH_QUESTION);
    end else if (r < 96) begin
      stim_q.push_back(sb.introducer);
    end else begin
      stim_q.push_back(BYTE_W'($urandom_range(255)));
    end
    if ($urandom_range(4) == 0) begin
      for (int n = $urandom_range(4, 1); n > 0; n--) stim_q.push_back(BYTE_W'($urandom_range(255)));
    end
  endfunction

  // Take result items and drive the stall for the next cycle
  initial begin
    csi_param_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        got.letter   = out_final_letter;
        got.index    = out_param_index;
        got.value    = out_param_value;
        got.total    = out_param_total;
        got.too_many = out_too_many;
        got.last     = out_last;
        sb.match_param(got);
      end
      @(negedge clk);
      out_stall = (dst_stall_pct != 0) && ($urandom_range(99) < dst_stall_pct);
    end
  end

  // Count cycles in which no item moves on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("ansi_csi_sequence_parser_test failed");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme bytes, bare sequence, saturation with empty params,
    // question mark abort, introducer inside a sequence restarting one
    stim_q = '{8'h00, 8'hFF,
               INTRODUCER_RST, OPENING_RST, CH_UP_A,
               INTRODUCER_RST, OPENING_RST, CH_ZERO + 8'd7, CH_ZERO, CH_ZERO, CH_ZERO,
               CH_ZERO, CH_SEMI, CH_SEMI, CH_LO_Z,
               INTRODUCER_RST, OPENING_RST, CH_QUESTION,
               INTRODUCER_RST, OPENING_RST, CH_ZERO + 8'd5, INTRODUCER_RST, OPENING_RST,
               CH_ZERO + 8'd2, CH_LO_A + 8'd12};
    while (stim_q.size() < ITEMS_PER_PHASE) add_sequence();
    run_phase();

    // Random phases over several start pairs and idling patterns
    for (int phase = 1; phase <= 4; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_INTRODUCER, 8'h00);
          write_reg(REG_OPENING, 8'hFF);
          src_idle_pct = 45;
          dst_stall_pct = 0;
        end
        2: begin
          write_reg(REG_INTRODUCER, 8'hFF);
          write_reg(REG_OPENING, 8'h00);
          src_idle_pct = 0;
          dst_stall_pct = 45;
        end
        3: begin
          write_reg(REG_INTRODUCER, BYTE_W'($urandom_range(255)));
          write_reg(REG_OPENING, BYTE_W'($urandom_range(255)));
          src_idle_pct = 15;
          dst_stall_pct = 15;
        end
        default: begin
          write_reg(REG_INTRODUCER, INTRODUCER_RST);
          write_reg(REG_OPENING, OPENING_RST);
          src_idle_pct = 0;
          dst_stall_pct = 0;
        end
      endcase
      while (stim_q.size() < ITEMS_PER_PHASE) add_sequence();
      run_phase();
    end

    if (sb.errors == 0) begin
      $display("ansi_csi_sequence_parser_test passed");
    end else begin
      $display("ansi_csi_sequence_parser_test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/csi_pkg.sv
hdl/csi_ctrl.sv
hdl/csi_dp.sv
hdl/ansi_csi_sequence_parser.sv
bench/ansi_csi_sequence_parser_test.sv
